/* hdl/hop_receiver_link_tracker_core_macros.svh */
// ----------------------------------------------------------------------------
// Hop receiver link tracker - assertion macros
// Shared property forms for the tracker; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HOP_RECEIVER_LINK_TRACKER_CORE_MACROS_SVH
`define HOP_RECEIVER_LINK_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define HRLT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define HRLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/hrlt_pkg.sv */
// ----------------------------------------------------------------------------
// hrlt_pkg
// Types, codes and sizes shared by the hop receiver link tracker.
// ----------------------------------------------------------------------------
package hrlt_pkg;

    // Hop sequence sizes (SEQ_COUNT is a power of two)
    localparam int SEQ_COUNT = 32;
    localparam int HALF_SEQ  = SEQ_COUNT / 2;
    localparam int SEQ_W     = $clog2(SEQ_COUNT);
    localparam int RUN_W     = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 20;

    // Event codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_PACKET  = 2'd1;
    localparam logic [1:0] OP_TX_DONE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PKT_PERIOD      = 1'b0;
    localparam logic CFG_DEADLINE_MARGIN = 1'b1;

    // Reset values
    localparam logic [CFG_W-1:0]  PKT_PERIOD_RST = CFG_W'(20000);
    localparam logic [CFG_W-1:0]  MARGIN_RST     = CFG_W'(2000);

    // Link phase, one-hot
    typedef enum logic [1:0] {
        PH_LISTEN = 2'b01,
        PH_REPLY  = 2'b10
    } phase_t;

    // One input request
    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] now;
        logic [4:0]        packet_seq;
        logic              rx_busy;
    } event_t;

    // One result
    typedef struct packed {
        logic        link_phase;
        logic        start_reply;
        logic [4:0]  reply_ack_seq;
        logic [4:0]  hop_index;
        logic        retune;
        logic        packet_lost;
        logic [15:0] lost_run;
        logic        deadline_extended;
    } result_t;

    // Configuration values held in the top level
    typedef struct packed {
        logic [CFG_W-1:0] pkt_period;
        logic [CFG_W-1:0] deadline_margin;
    } cfg_t;

endpackage

/* hdl/hop_receiver_link_tracker_core.sv */
// ----------------------------------------------------------------------------
// hop_receiver_link_tracker_core
// Receiver-side hop and loss tracking for a frequency-hopping link.
//
// Channel   Signals                         Carries
// s_        s_tvalid/s_tready/s_tdata/tuser one event request
// m_        m_tvalid/m_tready/m_tdata       one result per event
// cfg_      cfg_valid/cfg_ready/index/data  cycle time, deadline margin
//
// One event per cycle sustained while m_tready stays high; each event passes the
// input register, then the single-pass update into the result register.
// Reset is asynchronous, active low; control flags, link state and config return to defaults.
// The input register keeps accepting while the result register is full and
// being drained; only a full result register under m_tready low holds it.
// Config writes are always ready and take effect on the next event.
// ----------------------------------------------------------------------------
`include "hop_receiver_link_tracker_core_macros.svh"

module hop_receiver_link_tracker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // now[31:0], packet_seq[36:32], rx_busy[37], zero[39:38]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // link_phase[0], start_reply[1], reply_ack_seq[6:2],
                                   // hop_index[11:7], retune[12], packet_lost[13],
                                   // lost_run[29:14], deadline_extended[30], zero[31]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data
);
    import hrlt_pkg::*;

    logic    in_valid_reg,  in_valid_next;
    event_t  in_event_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;
    cfg_t    cfg_reg;
    result_t res;
    logic    advance;
    logic    fire;
    logic    s_take;

    // Handshake: result stage drains or is empty, input stage follows
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign s_take    = s_tvalid && s_tready;
    assign fire      = in_valid_reg && advance;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // Hold the control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming request
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_event_reg.opcode     <= s_tuser;
            in_event_reg.now        <= s_tdata[31:0];
            in_event_reg.packet_seq <= s_tdata[36:32];
            in_event_reg.rx_busy    <= s_tdata[37];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pkt_period      <= PKT_PERIOD_RST;
            cfg_reg.deadline_margin <= MARGIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PKT_PERIOD:      cfg_reg.pkt_period      <= cfg_data;
                CFG_DEADLINE_MARGIN: cfg_reg.deadline_margin <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    hrlt_link_state u_link_state (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .evt   (in_event_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_result_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_result_reg.deadline_extended,
                       out_result_reg.lost_run,
                       out_result_reg.packet_lost,
                       out_result_reg.retune,
                       out_result_reg.hop_index,
                       out_result_reg.reply_ack_seq,
                       out_result_reg.start_reply,
                       out_result_reg.link_phase};

    // Checks
    `HRLT_ASSERT_IMP(a_reply_clears_run,
        out_valid_reg && out_result_reg.start_reply,
        out_result_reg.link_phase && out_result_reg.lost_run == '0 &&
        !out_result_reg.packet_lost,
        "reply started without clean replying state")

    `HRLT_ASSERT_IMP(a_loss_while_listening,
        out_valid_reg && out_result_reg.packet_lost,
        !out_result_reg.link_phase && out_result_reg.lost_run != '0 &&
        !out_result_reg.deadline_extended,
        "loss reported with inconsistent state")

    `HRLT_ASSERT_NEXT(a_fire_gives_result,
        fire,
        out_valid_reg,
        "processed request produced no result")

endmodule

/* hdl/hrlt_hop_calc.sv */
// ----------------------------------------------------------------------------
// hrlt_hop_calc
// Expected hop channel from the last sequence number and the loss run.
// ----------------------------------------------------------------------------
module hrlt_hop_calc (
    input  logic [hrlt_pkg::SEQ_W-1:0] last_seq,
    input  logic [hrlt_pkg::RUN_W-1:0] run,
    output logic [hrlt_pkg::SEQ_W-1:0] hop
);
    import hrlt_pkg::*;

    localparam logic [RUN_W-1:0] HALF_RUN = RUN_W'(HALF_SEQ);
    localparam logic [SEQ_W-1:0] HALF_HOP = SEQ_W'(HALF_SEQ);
    localparam logic [SEQ_W-1:0] ONE_HOP  = SEQ_W'(1);

    logic [RUN_W-1:0] excess;
    logic [SEQ_W-1:0] dec;

    // Losses beyond half a cycle, four per channel, taken modulo the hop count
    assign excess = run - HALF_RUN;
    assign dec    = excess[SEQ_W+1:2];

    // Step backward once past half a cycle, otherwise follow the hop pattern
    always_comb
    begin
        if (run > HALF_RUN)
        begin
            hop = last_seq + HALF_HOP - dec;
        end
        else
        begin
            hop = last_seq + ONE_HOP + run[SEQ_W-1:0];
        end
    end

endmodule

/* hdl/hrlt_link_state.sv */
// ----------------------------------------------------------------------------
// hrlt_link_state
// Link state registers and the single-pass event update that drives them.
// ----------------------------------------------------------------------------
module hrlt_link_state (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  hrlt_pkg::event_t  evt,
    input  hrlt_pkg::cfg_t    cfg,
    output hrlt_pkg::result_t res
);
    import hrlt_pkg::*;

    localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    phase_t            phase_reg,    phase_next;
    logic [SEQ_W-1:0]  last_seq_reg, last_seq_next;
    logic [SEQ_W-1:0]  channel_reg,  channel_next;
    logic [RUN_W-1:0]  run_reg,      run_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic              ext_reg,      ext_next;

    logic [TIME_W+1:0] arm_sum;
    logic [TIME_W-1:0] arm_deadline;
    logic [TIME_W:0]   ext_sum;
    logic [TIME_W-1:0] ext_deadline;
    logic              expired;
    logic [RUN_W-1:0]  run_inc;
    logic [RUN_W-1:0]  hop_run;
    logic [SEQ_W-1:0]  hop;
    logic              start;
    logic              lost;
    logic              retune;

    // Fresh deadline: now + cycle time + margin, saturating
    assign arm_sum      = {2'b00, evt.now} + {(TIME_W+2-CFG_W)'(0), cfg.pkt_period}
                        + {(TIME_W+2-CFG_W)'(0), cfg.deadline_margin};
    assign arm_deadline = (|arm_sum[TIME_W+1:TIME_W]) ? TIME_MAX : arm_sum[TIME_W-1:0];

    // One-time extension of the current deadline, saturating
    assign ext_sum      = {1'b0, deadline_reg} + {(TIME_W+1-CFG_W)'(0), cfg.deadline_margin};
    assign ext_deadline = ext_sum[TIME_W] ? TIME_MAX : ext_sum[TIME_W-1:0];

    assign expired = evt.now > deadline_reg;
    assign run_inc = (run_reg == RUN_MAX) ? run_reg : run_reg + RUN_W'(1);

    // A tick that reaches the hop choice has already counted its loss
    assign hop_run = (evt.opcode == OP_TICK) ? run_inc : run_reg;

    hrlt_hop_calc u_hop_calc (
        .last_seq (last_seq_reg),
        .run      (hop_run),
        .hop      (hop)
    );

    // Event update
    always_comb
    begin
        phase_next    = phase_reg;
        last_seq_next = last_seq_reg;
        channel_next  = channel_reg;
        run_next      = run_reg;
        deadline_next = deadline_reg;
        ext_next      = ext_reg;
        start         = 1'b0;
        lost          = 1'b0;
        retune        = 1'b0;
        if (phase_reg == PH_LISTEN && evt.opcode == OP_PACKET)
        begin
            last_seq_next = evt.packet_seq[SEQ_W-1:0];
            run_next      = '0;
            deadline_next = arm_deadline;
            ext_next      = 1'b0;
            phase_next    = PH_REPLY;
            start         = 1'b1;
        end
        else if (phase_reg == PH_REPLY && evt.opcode == OP_TX_DONE)
        begin
            channel_next = hop;
            retune       = (hop != channel_reg);
            phase_next   = PH_LISTEN;
        end
        else if (phase_reg == PH_LISTEN && evt.opcode == OP_TICK && expired)
        begin
            if (!ext_reg && evt.rx_busy)
            begin
                deadline_next = ext_deadline;
                ext_next      = 1'b1;
            end
            else
            begin
                run_next      = run_inc;
                deadline_next = arm_deadline;
                ext_next      = 1'b0;
                lost          = 1'b1;
                channel_next  = hop;
                retune        = (hop != channel_reg);
            end
        end
    end

    // Result after the event
    always_comb
    begin
        res.link_phase        = (phase_next == PH_REPLY);
        res.start_reply       = start;
        res.reply_ack_seq     = 5'(last_seq_next);
        res.hop_index         = 5'(channel_next);
        res.retune            = retune;
        res.packet_lost       = lost;
        res.lost_run          = run_next;
        res.deadline_extended = ext_next;
    end

    // Advance the state on each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LISTEN;
            last_seq_reg <= '0;
            channel_reg  <= '0;
            run_reg      <= '0;
            deadline_reg <= TIME_MAX;
            ext_reg      <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            last_seq_reg <= last_seq_next;
            channel_reg  <= channel_next;
            run_reg      <= run_next;
            deadline_reg <= deadline_next;
            ext_reg      <= ext_next;
        end
    end

endmodule
